### src/assert_macros.svh
// ----------------------------------------------------------------------------
// Assertion macros
// Short forms for clocked implication checks on clk, disabled while rst is set.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication
`define ASSERT_IMP(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

### src/mvss_pkg.sv
// ----------------------------------------------------------------------------
// mvss_pkg
// Shared sizes and codes of the three-voice sine and envelope synthesizer.
// ----------------------------------------------------------------------------
package mvss_pkg;

  localparam int VOICES         = 3;
  localparam int SINE_ADDR_BITS = 10;
  localparam int PHASE_BITS     = 32;

  localparam int SINE_BITS  = 16;
  localparam int LEVEL_BITS = 24;

  typedef logic [SINE_ADDR_BITS-1:0]  sine_addr_t;
  typedef logic signed [SINE_BITS-1:0] sine_t;

  typedef enum logic [1:0] {
    CMD_TICK    = 2'd0,
    CMD_KEY_ON  = 2'd1,
    CMD_KEY_OFF = 2'd2,
    CMD_UNUSED  = 2'd3
  } cmd_t;

  typedef enum logic [1:0] {
    MODE_IDLE    = 2'd0,
    MODE_ATTACK  = 2'd1,
    MODE_RELEASE = 2'd2
  } env_mode_t;

  typedef enum logic [2:0] {
    REG_STEP0       = 3'd0,
    REG_STEP1       = 3'd1,
    REG_STEP2       = 3'd2,
    REG_MAX_LEVEL   = 3'd3,
    REG_FLOOR_LEVEL = 3'd4,
    REG_START_LEVEL = 3'd5,
    REG_ATTACK_GAIN = 3'd6,
    REG_DECAY_GAIN  = 3'd7
  } reg_index_t;

endpackage

### src/mvss_sine_rom.sv
// ----------------------------------------------------------------------------
// mvss_sine_rom
// Full-wave Q1.15 sine table with a registered read port. The table is built
// at elaboration from quarter-wave symmetry and a fixed-point Taylor series.
// ----------------------------------------------------------------------------
module mvss_sine_rom (
  input  logic               clk,
  input  mvss_pkg::sine_addr_t addr,
  output mvss_pkg::sine_t    data
);
  import mvss_pkg::*;

  localparam int ROM_SIZE     = 1 << SINE_ADDR_BITS;
  localparam int QUARTER_BITS = SINE_ADDR_BITS - 2;
  localparam int QUARTER_SIZE = 1 << QUARTER_BITS;
  localparam logic [63:0] HALF_PI_Q48 = 64'h0001921FB54442D1;

  typedef logic signed [SINE_BITS-1:0] rom_t [ROM_SIZE];

  // sin(pi/2 * q / QUARTER_SIZE) scaled to 32767, rounded
  function automatic logic [15:0] quarter_sine(input logic [63:0] q);
    logic [63:0] x;
    logic [63:0] x2;
    logic [63:0] term;
    logic [63:0] sum;
    logic [63:0] m;
    x    = (q * HALF_PI_Q48 + (64'd1 << (QUARTER_BITS + 17))) >> (QUARTER_BITS + 18);
    x2   = (x * x) >> 30;
    term = x;
    sum  = x;
    term = ((term * x2) >> 30) / 64'd6;   sum = sum - term;
    term = ((term * x2) >> 30) / 64'd20;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd42;  sum = sum - term;
    term = ((term * x2) >> 30) / 64'd72;  sum = sum + term;
    term = ((term * x2) >> 30) / 64'd110; sum = sum - term;
    term = ((term * x2) >> 30) / 64'd156; sum = sum + term;
    term = ((term * x2) >> 30) / 64'd210; sum = sum - term;
    m = (sum * 64'd32767 + (64'd1 << 29)) >> 30;
    if (m > 64'd32767) begin
      m = 64'd32767;
    end
    return m[15:0];
  endfunction

  function automatic rom_t build_rom();
    rom_t        t;
    logic [63:0] r;
    logic [15:0] m;
    for (int i = 0; i < ROM_SIZE; i++) begin
      r = 64'(i % QUARTER_SIZE);
      if (((i / QUARTER_SIZE) % 2) == 1) begin
        m = quarter_sine(64'(QUARTER_SIZE) - r);
      end else begin
        m = quarter_sine(r);
      end
      if (((i / QUARTER_SIZE) / 2) == 1) begin
        t[i] = -$signed(m);
      end else begin
        t[i] = $signed(m);
      end
    end
    return t;
  endfunction

  localparam rom_t SINE_ROM = build_rom();

  always_ff @(posedge clk) begin
    data <= SINE_ROM[addr];
  end

endmodule

### src/multi_voice_sine_envelope_synth.sv
// ----------------------------------------------------------------------------
// multi_voice_sine_envelope_synth
// Three-voice sine synthesizer with exponential attack and release envelopes.
// One shared multiplier serves the sine product and the envelope gain.
// ----------------------------------------------------------------------------
//  channel | signals                         | direction | beat
//  in      | in_valid, in_stall, command, voice | in     | valid & !stall
//  out     | out_valid, out_stall, sample     | out      | valid & !stall
//  cfg     | cfg_en, cfg_index, cfg_data      | in       | cfg_en
//
//  A key-on or key-off beat is taken without a stall and sets the voice's
//  envelope mode. A tick runs the sequencer over each voice in turn (ROM
//  read, sine multiply, accumulate, and for an active envelope a gain
//  multiply and a level write) and then an output step: in_stall stays
//  high until the sample loads, so no new beat is taken during a tick.
//  A finished sample waits in the output register and the next input beat
//  may be taken meanwhile; a tick ending while that sample is stalled holds.
//  Synchronous reset clears phases, levels and envelope modes and restores
//  the register defaults.
`include "assert_macros.svh"

module multi_voice_sine_envelope_synth (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [1:0]  command,
  input  logic [1:0]  voice,
  output logic        out_valid,
  input  logic        out_stall,
  output logic signed [23:0] sample,
  input  logic        cfg_en,
  input  logic [2:0]  cfg_index,
  input  logic [31:0] cfg_data
);
  import mvss_pkg::*;

  localparam int VI_BITS  = (VOICES > 1) ? $clog2(VOICES) : 1;
  localparam int SUM_BITS = LEVEL_BITS + $clog2(VOICES + 1) + 1;
  localparam int PROD_BITS = LEVEL_BITS + 31;
  localparam logic [LEVEL_BITS-1:0] LEVEL_MAX = '1;

  localparam logic [2:0] S_IDLE = 3'd0;
  localparam logic [2:0] S_ROM  = 3'd1;
  localparam logic [2:0] S_MULS = 3'd2;
  localparam logic [2:0] S_ACC  = 3'd3;
  localparam logic [2:0] S_MULE = 3'd4;
  localparam logic [2:0] S_ENV  = 3'd5;
  localparam logic [2:0] S_DONE = 3'd6;

  localparam logic [31:0] STEP_RESET [3] = '{32'd21426139, 32'd16051495, 32'd13497622};

  // configuration
  logic [PHASE_BITS-1:0] step [VOICES];
  logic [LEVEL_BITS-1:0] max_level;
  logic [LEVEL_BITS-1:0] floor_level;
  logic [LEVEL_BITS-1:0] start_level;
  logic [30:0]           attack_gain;
  logic [30:0]           decay_gain;

  // voice state
  logic [PHASE_BITS-1:0] phase [VOICES];
  logic [LEVEL_BITS-1:0] level [VOICES];
  logic [1:0]            mode  [VOICES];

  // sequencer
  logic [2:0]               state;
  logic [VI_BITS-1:0]       vi;
  logic signed [SUM_BITS-1:0] sum;
  logic                     neg;
  logic                     env_attack;
  logic [LEVEL_BITS-1:0]    op_level;
  logic [PROD_BITS-1:0]     prod;

  sine_t      rom_data;
  sine_addr_t rom_addr;

  logic [LEVEL_BITS-1:0] cur_level;
  logic [1:0]            cur_mode;
  logic [LEVEL_BITS:0]   kick;
  logic [LEVEL_BITS-1:0] kicked;
  logic [SINE_BITS-1:0]  rom_mag;
  logic [LEVEL_BITS-1:0] mul_a;
  logic [30:0]           mul_b;
  logic [SUM_BITS-1:0]   mag_ext;
  logic [PROD_BITS:0]    attack_rnd;
  logic [PROD_BITS-30:0] env_raw;
  logic [LEVEL_BITS-1:0] env_level;
  logic signed [23:0]    sum_sat;
  logic                  load_out;

  assign cur_level = level[vi];
  assign cur_mode  = mode[vi];
  assign rom_addr  = phase[vi][PHASE_BITS-1 -: SINE_ADDR_BITS];

  mvss_sine_rom u_rom (
    .clk  (clk),
    .addr (rom_addr),
    .data (rom_data)
  );

  assign rom_mag = rom_data[SINE_BITS-1] ? SINE_BITS'(-rom_data) : rom_data;

  // shared multiplier operand select
  always_comb begin
    if (state == S_MULS) begin
      mul_a = cur_level;
      mul_b = 31'(rom_mag);
    end else begin
      mul_a = op_level;
      mul_b = env_attack ? attack_gain : decay_gain;
    end
  end

  assign kick   = {1'b0, cur_level} + {1'b0, start_level};
  assign kicked = (cur_level < start_level) ? (kick[LEVEL_BITS] ? LEVEL_MAX : kick[LEVEL_BITS-1:0])
                                            : cur_level;

  assign mag_ext    = SUM_BITS'(prod[PROD_BITS-1:16]);
  assign attack_rnd = {1'b0, prod} + (PROD_BITS+1)'((64'd1 << 30) - 64'd1);
  assign env_raw    = env_attack ? attack_rnd[PROD_BITS:30] : {1'b0, prod[PROD_BITS-1:30]};
  assign env_level  = (env_raw > (PROD_BITS-29)'(LEVEL_MAX)) ? LEVEL_MAX : env_raw[LEVEL_BITS-1:0];

  always_comb begin
    if (sum > SUM_BITS'(signed'(24'sh7FFFFF))) begin
      sum_sat = 24'sh7FFFFF;
    end else if (sum < SUM_BITS'(signed'(24'sh800000))) begin
      sum_sat = 24'sh800000;
    end else begin
      sum_sat = sum[23:0];
    end
  end

  assign in_stall = (state != S_IDLE);
  assign load_out = (state == S_DONE) && (!out_valid || !out_stall);

  always_ff @(posedge clk) begin
    if (state == S_MULS || state == S_MULE) begin
      prod <= {{(PROD_BITS-LEVEL_BITS){1'b0}}, mul_a} * {{(PROD_BITS-31){1'b0}}, mul_b};
    end
    if (state == S_MULS) begin
      neg <= rom_data[SINE_BITS-1];
    end
    if (load_out) begin
      sample <= sum_sat;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state       <= S_IDLE;
      vi          <= '0;
      sum         <= '0;
      env_attack  <= 1'b0;
      op_level    <= '0;
      out_valid   <= 1'b0;
      max_level   <= 24'd838861;
      floor_level <= 24'd168;
      start_level <= 24'd168;
      attack_gain <= 31'd1073849198;
      decay_gain  <= 31'd1073688137;
      for (int v = 0; v < VOICES; v++) begin
        step[v]  <= (v < 3) ? STEP_RESET[v][PHASE_BITS-1:0] : '0;
        phase[v] <= '0;
        level[v] <= '0;
        mode[v]  <= MODE_IDLE;
      end
    end else begin
      if (cfg_en) begin
        for (int v = 0; v < VOICES; v++) begin
          if (v < 3 && cfg_index == REG_STEP0 + 3'(v)) begin
            step[v] <= cfg_data[PHASE_BITS-1:0];
          end
        end
        case (cfg_index)
          REG_MAX_LEVEL:   max_level   <= cfg_data[LEVEL_BITS-1:0];
          REG_FLOOR_LEVEL: floor_level <= cfg_data[LEVEL_BITS-1:0];
          REG_START_LEVEL: start_level <= cfg_data[LEVEL_BITS-1:0];
          REG_ATTACK_GAIN: attack_gain <= cfg_data[30:0];
          REG_DECAY_GAIN:  decay_gain  <= cfg_data[30:0];
          default: ;
        endcase
      end

      // load a new sample, else drop the old one once taken
      if (load_out) begin
        out_valid <= 1'b1;
      end else if (out_valid && !out_stall) begin
        out_valid <= 1'b0;
      end

      case (state)
        S_IDLE: begin
          if (in_valid) begin
            if (command == CMD_TICK) begin
              vi    <= '0;
              sum   <= '0;
              state <= S_ROM;
            end else if (command == CMD_KEY_ON || command == CMD_KEY_OFF) begin
              for (int v = 0; v < VOICES; v++) begin
                if ({30'd0, voice} == 32'(v)) begin
                  mode[v] <= (command == CMD_KEY_ON) ? MODE_ATTACK : MODE_RELEASE;
                end
              end
            end
          end
        end
        S_ROM:  state <= S_MULS;
        S_MULS: state <= S_ACC;
        S_ACC: begin
          sum <= neg ? sum - signed'(mag_ext) : sum + signed'(mag_ext);
          phase[vi] <= phase[vi] + step[vi];
          state <= S_MULE;
          if (cur_mode == MODE_ATTACK && cur_level < max_level) begin
            env_attack <= 1'b1;
            op_level   <= kicked;
          end else if (cur_mode == MODE_RELEASE && cur_level > floor_level) begin
            env_attack <= 1'b0;
            op_level   <= cur_level;
          end else begin
            if (cur_mode == MODE_ATTACK) begin
              level[vi] <= max_level;
              mode[vi]  <= MODE_IDLE;
            end else if (cur_mode == MODE_RELEASE) begin
              level[vi] <= '0;
              mode[vi]  <= MODE_IDLE;
            end
            // no gain step: advance to the next voice, or finish after the last
            if (32'(vi) == VOICES - 1) begin
              state <= S_DONE;
            end else begin
              vi    <= vi + 1'b1;
              state <= S_ROM;
            end
          end
        end
        S_MULE: state <= S_ENV;
        S_ENV: begin
          level[vi] <= env_level;
          if (32'(vi) == VOICES - 1) begin
            state <= S_DONE;
          end else begin
            vi    <= vi + 1'b1;
            state <= S_ROM;
          end
        end
        S_DONE: begin
          if (load_out) begin
            state <= S_IDLE;
          end
        end
        default: state <= S_IDLE;
      endcase
    end
  end

  `ASSERT_NEXT(a_tick_starts, in_valid && !in_stall && command == CMD_TICK, state == S_ROM, "tick beat did not start the voice sweep")
  `ASSERT_IMP(a_voice_range, state == S_ACC || state == S_ENV, 32'(vi) < VOICES, "voice index out of range")
  `ASSERT_IMP(a_out_from_done, $rose(out_valid), $past(state) == S_DONE, "sample loaded outside the output step")

endmodule
